// ===== hdl/vvf_pkg.sv =====
// Shared types, field widths and codes for the visited vertex filter.
// Depends on nothing; imported by visited_vertex_filter and by the bench.
`default_nettype none

package vvf_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 4096;
    localparam int unsigned VERTEX_W        = 63;
    localparam int unsigned LABEL_W         = 31;
    localparam int unsigned ENTRY_W         = VERTEX_W + LABEL_W;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_FILTER = 2'd2;

    localparam logic KIND_KEPT   = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef enum logic [1:0] {
        CMP_LT,
        CMP_EQ,
        CMP_GT
    } t_cmp;

    // Compare table entry (tv, tl) against key (v, l).
    function automatic t_cmp vvf_key_cmp(
        input logic [VERTEX_W-1:0] tv,
        input logic [LABEL_W-1:0]  tl,
        input logic [VERTEX_W-1:0] v,
        input logic [LABEL_W-1:0]  l,
        input logic                use_labels
    );
        t_cmp res;
        if (tv < v) begin
            res = CMP_LT;
        end else if (tv > v) begin
            res = CMP_GT;
        end else if (use_labels && (tl < l)) begin
            res = CMP_LT;
        end else if (use_labels && (tl > l)) begin
            res = CMP_GT;
        end else begin
            res = CMP_EQ;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/visited_vertex_filter.sv =====
// Visited vertex filter: sorted visited table in one memory, searched by a shared
// compare unit under a small sequencer. Depends on vvf_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries operation, vertex and label.
//   Clear empties the table, append adds an entry at the tail, filter looks the
//   item up and passes it on only if no entry matches.
//   Output channel (o_out_valid / i_out_ready) carries kind, vertex and label:
//   kept frontier items and rejected appends (table full or out of order).
//   Config channel (i_cfg_valid / o_cfg_ready) writes use_labels; always ready.
//   Clear acts in the idle state; append writes an empty table at once, else
//   first compares against the tail entry; filter binary-searches for the lower
//   bound, checks the entry it lands on, then loads the output register.
//   One beat is in work at a time; each probe goes through the single registered
//   read port of the table memory and the one key comparator.
//   A finished result sits in the output register; the next beat is accepted
//   while it waits. If the receiver stalls and a second result is ready, the
//   sequencer holds in its emit state until the output register frees.
//   Reset empties the table (count only, memory is not swept) and clears
//   use_labels; no clearing pass is needed.
`default_nettype none

module visited_vertex_filter
    import vvf_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_operation,
    input  wire logic [VERTEX_W-1:0] i_vertex,
    input  wire logic [LABEL_W-1:0]  i_label,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic                     o_kind,
    output logic [VERTEX_W-1:0]      o_out_vertex,
    output logic [LABEL_W-1:0]       o_out_label,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_use_labels
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SEARCH,
        S_CHECK,
        S_EMIT
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_lo, n_lo;
    logic [CW-1:0]         r_hi, n_hi;
    logic [CW-1:0]         r_mid, n_mid;
    logic [VERTEX_W-1:0]   r_key_v, n_key_v;
    logic [LABEL_W-1:0]    r_key_l, n_key_l;
    logic                  r_kind, n_kind;
    logic                  r_use_labels, n_use_labels;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_kind, n_out_kind;
    logic [VERTEX_W-1:0]   r_out_vertex, n_out_vertex;
    logic [LABEL_W-1:0]    r_out_label, n_out_label;

    logic [ENTRY_W-1:0]    r_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]    r_rd_data;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    logic [ENTRY_W-1:0]    mem_wdata;

    t_cmp                  e_cmp;
    logic                  out_free;
    logic [CW-1:0]         lt_lo;
    logic [CW-1:0]         lt_mid;
    logic                  lt_go;
    logic [CW-1:0]         ge_mid;
    logic                  ge_go;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_out_vertex = r_out_vertex;
    assign o_out_label  = r_out_label;

    assign e_cmp    = vvf_key_cmp(r_rd_data[VERTEX_W-1:0], r_rd_data[ENTRY_W-1:VERTEX_W],
                                  r_key_v, r_key_l, r_use_labels);
    assign out_free = !r_out_valid || i_out_ready;

    // Both candidate probes of the next search step.
    assign lt_lo  = r_mid + CW'(1);
    assign lt_mid = lt_lo + ((r_hi - lt_lo) >> 1);
    assign lt_go  = (lt_lo < r_hi);
    assign ge_mid = r_lo + ((r_mid - r_lo) >> 1);
    assign ge_go  = (r_lo < r_mid);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_key_v      = r_key_v;
        n_key_l      = r_key_l;
        n_kind       = r_kind;
        n_use_labels = r_use_labels;
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_vertex = r_out_vertex;
        n_out_label  = r_out_label;
        mem_we       = 1'b0;
        mem_waddr    = r_count[AW-1:0];
        mem_wdata    = {r_key_l, r_key_v};
        mem_raddr    = r_mid[AW-1:0];

        if (i_cfg_valid) begin
            n_use_labels = i_cfg_use_labels;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key_v = i_vertex;
                    n_key_l = i_label;
                    unique case (i_operation)
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_APPEND: begin
                            if (r_count == DEPTH_C) begin
                                n_kind  = KIND_REJECT;
                                n_state = S_EMIT;
                            end else if (r_count == '0) begin
                                mem_we    = 1'b1;
                                mem_wdata = {i_label, i_vertex};
                                n_count   = r_count + CW'(1);
                            end else begin
                                mem_raddr = AW'(r_count - CW'(1));
                                n_state   = S_APPEND;
                            end
                        end
                        OP_FILTER: begin
                            n_lo  = '0;
                            n_hi  = r_count;
                            n_mid = r_count >> 1;
                            if (r_count != '0) begin
                                mem_raddr = n_mid[AW-1:0];
                                n_state   = S_SEARCH;
                            end else begin
                                mem_raddr = '0;
                                n_state   = S_CHECK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_APPEND: begin
                if (e_cmp == CMP_GT) begin
                    n_kind  = KIND_REJECT;
                    n_state = S_EMIT;
                end else begin
                    mem_we  = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = S_IDLE;
                end
            end
            S_SEARCH: begin
                if (e_cmp == CMP_LT) begin
                    n_lo  = lt_lo;
                    n_mid = lt_mid;
                    if (lt_go) begin
                        mem_raddr = lt_mid[AW-1:0];
                    end else begin
                        mem_raddr = lt_lo[AW-1:0];
                        n_state   = S_CHECK;
                    end
                end else begin
                    n_hi  = r_mid;
                    n_mid = ge_mid;
                    if (ge_go) begin
                        mem_raddr = ge_mid[AW-1:0];
                    end else begin
                        mem_raddr = r_lo[AW-1:0];
                        n_state   = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if ((r_lo < r_count) && (e_cmp == CMP_EQ)) begin
                    n_state = S_IDLE;
                end else begin
                    n_kind  = KIND_KEPT;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_kind;
                    n_out_vertex = r_key_v;
                    n_out_label  = r_use_labels ? r_key_l : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_use_labels <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_use_labels <= n_use_labels;
            r_out_valid  <= n_out_valid;
        end
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_key_v      <= n_key_v;
        r_key_l      <= n_key_l;
        r_kind       <= n_kind;
        r_out_kind   <= n_out_kind;
        r_out_vertex <= n_out_vertex;
        r_out_label  <= n_out_label;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("visited count above table depth");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> ((r_lo <= r_mid) && (r_mid < r_hi) && (r_hi <= r_count)))
        else $error("probe outside search window");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_count < DEPTH_C))
        else $error("table write while full");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_operation == OP_CLEAR)) |=> (r_count == '0))
        else $error("clear did not empty table");

    a_check_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_lo <= r_count))
        else $error("lower bound beyond table");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking bench for visited_vertex_filter: table loads, lookups, rejects and
// mode switches, under varying back-pressure. Depends on vvf_pkg and the RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vvf_pkg::*;

    localparam int unsigned DEPTH          = TABLE_DEPTH_DEF;
    localparam int unsigned RANDOM_ITEMS   = 1150;
    localparam int unsigned NUM_PHASES     = 8;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES    = 24;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;

    localparam logic [VERTEX_W-1:0] VMAX = {VERTEX_W{1'b1}};
    localparam logic [LABEL_W-1:0]  LMAX = {LABEL_W{1'b1}};

    typedef struct packed {
        logic                kind;
        logic [VERTEX_W-1:0] vertex;
        logic [LABEL_W-1:0]  label;
    } t_out_beat;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_TYPED
    } t_check;

    typedef struct {
        logic                mode;
        logic [1:0]          op;
        logic [VERTEX_W-1:0] vertex;
        logic [LABEL_W-1:0]  label;
        t_check              chk;
        t_out_beat           res;
    } t_row;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic [1:0]          i_operation      = OP_CLEAR;
    logic [VERTEX_W-1:0] i_vertex         = '0;
    logic [LABEL_W-1:0]  i_label          = '0;
    logic                i_out_ready      = 1'b0;
    logic                i_cfg_valid      = 1'b0;
    logic                i_cfg_use_labels = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_kind;
    logic [VERTEX_W-1:0] o_out_vertex;
    logic [LABEL_W-1:0]  o_out_label;
    logic                o_cfg_ready;

    logic [VERTEX_W-1:0] seen_vtx [DEPTH];
    logic [LABEL_W-1:0]  seen_lbl [DEPTH];
    int                  seen_count  = 0;
    logic                cmp_labels  = 1'b0;
    t_out_beat           out_beats_due[$];
    t_row                dir_rows[$];
    int                  mismatches  = 0;
    int                  items_sent  = 0;
    int                  tx_idle_pct  = 0;
    int                  rx_stall_pct = 0;
    bit                  rx_hold_req  = 1'b0;
    int unsigned         cycle_count  = 0;

    visited_vertex_filter u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_vertex         (i_vertex),
        .i_label          (i_label),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_out_vertex     (o_out_vertex),
        .o_out_label      (o_out_label),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_use_labels (i_cfg_use_labels)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VERTEX_W-1:0] rand_vtx();
        logic [63:0] r;
        r = rand64();
        return r[VERTEX_W-1:0];
    endfunction

    function automatic logic [LABEL_W-1:0] rand_lbl();
        logic [31:0] r;
        r = $urandom;
        return r[LABEL_W-1:0];
    endfunction

    function automatic t_cmp entry_vs(input int idx, input logic [VERTEX_W-1:0] v,
                                      input logic [LABEL_W-1:0] l);
        if (seen_vtx[idx] != v)
            return (seen_vtx[idx] < v) ? CMP_LT : CMP_GT;
        if (cmp_labels && seen_lbl[idx] != l)
            return (seen_lbl[idx] < l) ? CMP_LT : CMP_GT;
        return CMP_EQ;
    endfunction

    // lower bound, then equality on the landing entry
    function automatic bit table_has(input logic [VERTEX_W-1:0] v, input logic [LABEL_W-1:0] l);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = seen_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (entry_vs(mid, v, l) == CMP_LT) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return (lo < seen_count) && (entry_vs(lo, v, l) == CMP_EQ);
    endfunction

    function automatic bit table_step(input logic [1:0] op, input logic [VERTEX_W-1:0] v,
                                      input logic [LABEL_W-1:0] l, output t_out_beat r);
        bit reject;
        reject   = 1'b0;
        r.kind   = KIND_KEPT;
        r.vertex = v;
        r.label  = cmp_labels ? l : '0;
        if (op == OP_CLEAR) begin
            seen_count = 0;
            return 1'b0;
        end
        if (op == OP_APPEND) begin
            if (seen_count >= DEPTH) begin
                reject = 1'b1;
            end else if (seen_count > 0 && entry_vs(seen_count - 1, v, l) == CMP_GT) begin
                reject = 1'b1;
            end
            if (reject) begin
                r.kind = KIND_REJECT;
                return 1'b1;
            end
            seen_vtx[seen_count] = v;
            seen_lbl[seen_count] = l;
            seen_count++;
            return 1'b0;
        end
        if (op == OP_FILTER)
            return !table_has(v, l);
        return 1'b0;
    endfunction

    // next key at or above the last stored entry, leaving room for `left` more
    function automatic void next_entry(input int left, output logic [VERTEX_W-1:0] v,
                                       output logic [LABEL_W-1:0] l);
        logic [63:0] pv;
        logic [63:0] pl;
        logic [63:0] head;
        logic [63:0] span;
        logic [63:0] step;
        if (seen_count == 0) begin
            v = rand_vtx() >> $urandom_range(VERTEX_W - 1);
            l = rand_lbl() >> $urandom_range(LABEL_W - 1);
            return;
        end
        pv   = 64'(seen_vtx[seen_count - 1]);
        pl   = 64'(seen_lbl[seen_count - 1]);
        head = 64'(VMAX) - pv;
        case ($urandom_range(2))
            0: span = 64'd3;
            1: span = 64'd65535;
            default: span = head / 64'(left + 1);
        endcase
        if (span > head)
            span = head;
        step = (span == 0) ? 64'd0 : rand64() % (span + 1);
        v = VERTEX_W'(pv + step);
        if (step == 0) begin
            l = LABEL_W'(pl + rand64() % (64'(LMAX) - pl + 1));
        end else begin
            l = $urandom_range(1) ? rand_lbl() : rand_lbl() >> 24;
        end
    endfunction

    function automatic void lower_entry(output logic [VERTEX_W-1:0] v,
                                        output logic [LABEL_W-1:0] l);
        logic [VERTEX_W-1:0] pv;
        logic [LABEL_W-1:0]  pl;
        v = rand_vtx();
        l = rand_lbl();
        if (seen_count == 0)
            return;
        pv = seen_vtx[seen_count - 1];
        pl = seen_lbl[seen_count - 1];
        if (pv > 0 && $urandom_range(1)) begin
            v = VERTEX_W'(rand64() % 64'(pv));
        end else begin
            v = pv;
            if (pl > 0)
                l = LABEL_W'(rand64() % 64'(pl));
        end
    endfunction

    function automatic void pick_probe(output logic [VERTEX_W-1:0] v,
                                       output logic [LABEL_W-1:0] l);
        int r;
        int idx;
        r   = $urandom_range(99);
        idx = (seen_count > 0) ? $urandom_range(seen_count - 1) : 0;
        if (seen_count == 0 || r >= 75) begin
            v = rand_vtx() >> $urandom_range(VERTEX_W - 1);
            l = rand_lbl() >> $urandom_range(LABEL_W - 1);
        end else begin
            v = seen_vtx[idx];
            l = seen_lbl[idx];
            if (r >= 55) begin
                v = r[0] ? v + 1'b1 : v - 1'b1;
            end else if (r >= 40) begin
                l = rand_lbl();
            end
        end
    endfunction

    // entered and left just after a falling edge; valid stays up on exit
    task automatic offer(input logic [1:0] op, input logic [VERTEX_W-1:0] v,
                         input logic [LABEL_W-1:0] l, input t_check chk = CHK_MODEL,
                         input t_out_beat typed = '0);
        t_out_beat pred;
        bit        has;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_operation = op;
        i_vertex    = v;
        i_label     = l;
        do @(posedge i_clk); while (!o_in_ready);
        has = table_step(op, v, l, pred);
        if (chk == CHK_TYPED) begin
            out_beats_due.push_back(typed);
        end else if (chk == CHK_MODEL && has) begin
            out_beats_due.push_back(pred);
        end
        if (op != OP_UNUSED)
            items_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (out_beats_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_label_mode(input logic m);
        i_cfg_valid      = 1'b1;
        i_cfg_use_labels = m;
        do @(posedge i_clk); while (!o_cfg_ready);
        cmp_labels = m;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic add_row(input logic mode, input logic [1:0] op,
                           input logic [VERTEX_W-1:0] v, input logic [LABEL_W-1:0] l,
                           input t_check chk, input logic kind = KIND_KEPT,
                           input logic [VERTEX_W-1:0] rv = '0,
                           input logic [LABEL_W-1:0] rl = '0);
        t_row r;
        r.mode   = mode;
        r.op     = op;
        r.vertex = v;
        r.label  = l;
        r.chk    = chk;
        r.res    = '{kind: kind, vertex: rv, label: rl};
        dir_rows.push_back(r);
    endtask

    task automatic random_burst();
        logic [VERTEX_W-1:0] v;
        logic [LABEL_W-1:0]  l;
        int                  k;
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 6))
                offer(2'($urandom_range(3)), rand_vtx(), rand_lbl());
            return;
        end
        if ($urandom_range(99) < 60 || seen_count > DEPTH - 256)
            offer(OP_CLEAR, rand_vtx(), rand_lbl());
        k = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(24);
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(99) < 8) begin
                lower_entry(v, l);
            end else begin
                next_entry(k - i, v, l);
            end
            offer(OP_APPEND, v, l);
        end
        repeat ($urandom_range(1, 30)) begin
            pick_probe(v, l);
            offer(OP_FILTER, v, l);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (out_beats_due.size() == 0) begin
                $error("unexpected beat: kind %0d vertex %0h label %0h",
                       o_kind, o_out_vertex, o_out_label);
                mismatches++;
            end else begin
                want = out_beats_due.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    mismatches++;
                end
                if (o_out_vertex !== want.vertex) begin
                    $error("out_vertex: expected %0h, got %0h", want.vertex, o_out_vertex);
                    mismatches++;
                end
                if (o_out_label !== want.label) begin
                    $error("out_label: expected %0h, got %0h", want.label, o_out_label);
                    mismatches++;
                end
            end
        end
    end

    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_out_ready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin : stimulus
        logic [VERTEX_W-1:0] v;
        logic [LABEL_W-1:0]  l;
        int                  goal;
        int                  tx_pct [4];
        int                  rx_pct [4];
        tx_pct = '{0, 82, 0, 17};
        rx_pct = '{0, 0, 82, 17};

        add_row(0, OP_FILTER, 0, 0, CHK_TYPED, KIND_KEPT, 0, 0);
        add_row(0, OP_FILTER, VMAX, LMAX, CHK_TYPED, KIND_KEPT, VMAX, 0);
        add_row(0, OP_APPEND, 10, 5, CHK_NONE);
        add_row(0, OP_APPEND, 10, 3, CHK_NONE);
        add_row(0, OP_APPEND, 9, LMAX, CHK_TYPED, KIND_REJECT, 9, 0);
        add_row(0, OP_FILTER, 10, 77, CHK_NONE);
        add_row(0, OP_FILTER, 9, 0, CHK_TYPED, KIND_KEPT, 9, 0);
        add_row(0, OP_FILTER, 11, LMAX, CHK_TYPED, KIND_KEPT, 11, 0);
        add_row(0, OP_UNUSED, 10, 5, CHK_NONE);
        add_row(0, OP_APPEND, VMAX, 0, CHK_NONE);
        add_row(0, OP_FILTER, VMAX, LMAX, CHK_NONE);
        add_row(0, OP_CLEAR, 0, 0, CHK_NONE);
        add_row(0, OP_FILTER, 10, 5, CHK_TYPED, KIND_KEPT, 10, 0);
        add_row(1, OP_APPEND, 0, 0, CHK_NONE);
        add_row(1, OP_APPEND, 0, LMAX, CHK_NONE);
        add_row(1, OP_APPEND, 5, 7, CHK_NONE);
        add_row(1, OP_APPEND, 5, 6, CHK_TYPED, KIND_REJECT, 5, 6);
        add_row(1, OP_APPEND, 5, 7, CHK_NONE);
        add_row(1, OP_FILTER, 0, LMAX, CHK_NONE);
        add_row(1, OP_FILTER, 0, 1, CHK_MODEL);
        add_row(1, OP_FILTER, 5, 7, CHK_MODEL);
        add_row(1, OP_FILTER, VMAX, LMAX, CHK_TYPED, KIND_KEPT, VMAX, LMAX);
        add_row(1, OP_UNUSED, VMAX, LMAX, CHK_NONE);
        add_row(0, OP_FILTER, 5, 1, CHK_MODEL);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        set_label_mode(1'b0);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != cmp_labels) begin
                settle();
                set_label_mode(dir_rows[i].mode);
            end
            offer(dir_rows[i].op, dir_rows[i].vertex, dir_rows[i].label,
                  dir_rows[i].chk, dir_rows[i].res);
        end

        // fill to capacity, probe a deep table, then flip the compare mode on it
        settle();
        set_label_mode(1'b1);
        offer(OP_CLEAR, 0, 0);
        for (int i = 0; i < DEPTH; i++) begin
            next_entry(DEPTH - i, v, l);
            offer(OP_APPEND, v, l);
        end
        offer(OP_APPEND, VMAX, LMAX);
        offer(OP_APPEND, 0, 0);
        repeat (40) begin
            pick_probe(v, l);
            offer(OP_FILTER, v, l);
        end
        settle();
        set_label_mode(1'b0);
        repeat (20) begin
            pick_probe(v, l);
            offer(OP_FILTER, v, l);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            tx_idle_pct  = tx_pct[p % 4];
            rx_stall_pct = rx_pct[p % 4];
            set_label_mode(p == 1 ? 1'b1 : (p == 0 ? 1'b0 : 1'($urandom_range(1))));
            if (p == 0) begin
                offer(OP_CLEAR, 0, 0);
                rx_hold_req = 1'b1;
                repeat (40) offer(OP_FILTER, rand_vtx(), rand_lbl());
            end
            goal = items_sent + RANDOM_ITEMS / NUM_PHASES;
            while (items_sent < goal)
                random_burst();
        end

        settle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
